// ===== rtl/assert_macros.svh =====
// Shared assertion wrappers for the converter checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check, off while reset is held.
`define RSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rsc: check failed");

// Same, for checks on the handshake itself.
`define RSC_ASSERT_HS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rsc: handshake check failed");

`endif

// ===== rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int BASE_W      = 5;
  localparam int CHAR_W      = 8;
  localparam int ASCII_W     = 7;
  localparam int BIN_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int STORE_MAX   = 32;

  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd20;
  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_DIGIT = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_BASE = 1'b0,
    REG_TARGET_BASE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_READ,
    S_SHOW
  } state_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  // Digit value of a character; anything outside 0-9, A-J, a-j reads as zero.
  function automatic logic [BASE_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    t = '0;
    if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h4A) t = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h6A) t = c - 8'h57;
    return t[BASE_W-1:0];
  endfunction

  function automatic logic [ASCII_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [ASCII_W-1:0] t;
    if (d < 5'd10) t = 7'h30 + {2'b00, d};
    else t = 7'h37 + {2'b00, d};
    return t;
  endfunction

endpackage

// ===== rtl/rsc_if.sv =====
`timescale 1ns / 1ps

interface rsc_char_if;
  logic                      valid;
  logic                      ready;
  logic [rsc_pkg::CHAR_W-1:0] char_in;
  logic                      is_final;

  modport source (output valid, output char_in, output is_final, input ready);
  modport sink   (input valid, input char_in, input is_final, output ready);
endinterface

interface rsc_digit_if;
  logic                         valid;
  logic                         ready;
  logic [rsc_pkg::ASCII_W-1:0]  digit_out;
  logic [rsc_pkg::BIN_W-1:0]    binary_value;
  logic [rsc_pkg::STATUS_W-1:0] status;
  logic                         run_end;

  modport source (output valid, output digit_out, output binary_value, output status,
                  output run_end, input ready);
  modport sink   (input valid, input digit_out, input binary_value, input status,
                  input run_end, output ready);
endinterface

// ===== rtl/rsc_ram.sv =====
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/radix_string_converter.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                        Request when
// chars     in   char_in[7:0], is_final                         valid && ready
// digits    out  digit_out[6:0], binary_value[31:0], status,    valid && ready
//                run_end
// cfg       in   cfg_index, cfg_data[4:0]                       cfg_wen
//
// A character that adds a digit is taken first; the Horner step then runs
// bit-serially through the accumulator shift register, one bit a cycle.
// A bad or ignored character adds no digit. A final character then loads the
// divider, runs bit-serial division once per output digit, and reads each
// emitted digit from the store, then presents it until the output takes it.
// Reset is synchronous; it restores base 10 for both sides and clears the number.
// No character is taken while a run of digits is being built or delivered.

module radix_string_converter #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [rsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsc_pkg::BASE_W-1:0]      cfg_data,
  rsc_char_if.sink                        chars,
  rsc_digit_if.source                     digits
);

  import rsc_pkg::*;

  localparam int LIMIT = (MAX_DIGITS < STORE_MAX) ? MAX_DIGITS : STORE_MAX;
  localparam int AW    = $clog2(LIMIT);
  localparam int CW    = $clog2(LIMIT + 1);
  localparam int BCW   = $clog2(VALUE_BITS);
  localparam logic [BCW-1:0] BIT_LAST    = BCW'(VALUE_BITS - 1);
  localparam logic [CW-1:0]  COUNT_LIMIT = CW'(LIMIT);

  state_t                state, state_next;
  logic [BASE_W-1:0]     source_base, target_base;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] work;
  status_t               status;
  logic [BASE_W-1:0]     carry;
  logic [BASE_W-1:0]     rem;
  logic [BCW-1:0]        bit_cnt;
  logic                  nz;
  logic                  final_flag;
  logic [CW-1:0]         count;
  logic [AW-1:0]         idx;

  logic [BASE_W-1:0]     src_b, dst_b, in_digit;
  logic                  in_take, bad, last_bit, div_ge, more;
  logic [BASE_W:0]       mul_sum, div_part, div_rem;
  logic [CW-1:0]         count_inc;
  logic                  ram_we;
  logic [BASE_W-1:0]     ram_rdata;
  logic [BIN_W+VALUE_BITS-1:0] bin_ext;

  assign src_b     = clamp_base(source_base);
  assign dst_b     = clamp_base(target_base);
  assign in_digit  = char_value(chars.char_in);
  assign in_take   = chars.valid && chars.ready;
  assign bad       = (in_digit >= src_b);
  assign last_bit  = (bit_cnt == BIT_LAST);

  // Bit-serial Horner step, LSB first: carry never exceeds the base.
  assign mul_sum   = (acc[0] ? {1'b0, src_b} : '0) + {1'b0, carry};

  // Restoring division, MSB first; remainder stays below the base.
  assign div_part  = {rem, work[VALUE_BITS-1]};
  assign div_ge    = (div_part >= {1'b0, dst_b});
  assign div_rem   = div_ge ? (div_part - {1'b0, dst_b}) : div_part;
  assign count_inc = count + 1'b1;
  assign more      = (nz || div_ge) && (count_inc < COUNT_LIMIT);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (status == STATUS_BAD_DIGIT || bad) begin
            state_next = chars.is_final ? S_LOAD : S_IDLE;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (last_bit) state_next = final_flag ? S_LOAD : S_IDLE;
      end
      S_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (last_bit) state_next = more ? S_DIV : S_READ;
      end
      S_READ: state_next = S_SHOW;
      S_SHOW: begin
        if (digits.ready) state_next = (idx == '0) ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    chars.ready  = (state == S_IDLE);
    digits.valid = (state == S_SHOW);
    ram_we       = (state == S_DIV) && last_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      source_base <= BASE_RESET;
      target_base <= BASE_RESET;
      acc         <= '0;
      status      <= STATUS_OK;
      count       <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        case (reg_index_t'(cfg_index))
          REG_SOURCE_BASE: source_base <= cfg_data;
          REG_TARGET_BASE: target_base <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            final_flag <= chars.is_final;
            carry      <= in_digit;
            bit_cnt    <= '0;
            if (status != STATUS_BAD_DIGIT && bad) status <= STATUS_BAD_DIGIT;
          end
        end
        S_MUL: begin
          acc     <= {mul_sum[0], acc[VALUE_BITS-1:1]};
          carry   <= mul_sum[BASE_W:1];
          bit_cnt <= bit_cnt + 1'b1;
          if (last_bit) begin
            bit_cnt <= '0;
            // Bits left over the top mean the value no longer fits: saturate.
            if (mul_sum[BASE_W:1] != '0) begin
              acc    <= '1;
              status <= STATUS_OVERFLOW;
            end
          end
        end
        S_LOAD: begin
          work    <= acc;
          rem     <= '0;
          nz      <= 1'b0;
          bit_cnt <= '0;
          count   <= '0;
        end
        S_DIV: begin
          work    <= {work[VALUE_BITS-2:0], div_ge};
          rem     <= div_rem[BASE_W-1:0];
          nz      <= nz | div_ge;
          bit_cnt <= bit_cnt + 1'b1;
          if (last_bit) begin
            count   <= count_inc;
            idx     <= count[AW-1:0];
            rem     <= '0;
            nz      <= 1'b0;
            bit_cnt <= '0;
          end
        end
        S_READ: ;
        S_SHOW: begin
          if (digits.ready) begin
            if (idx == '0) begin
              acc    <= '0;
              status <= STATUS_OK;
              count  <= '0;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  rsc_ram #(
    .WIDTH (BASE_W),
    .DEPTH (LIMIT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (div_rem[BASE_W-1:0]),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign bin_ext             = {{BIN_W{1'b0}}, acc};
  assign digits.digit_out    = digit_char(ram_rdata);
  assign digits.binary_value = bin_ext[BIN_W-1:0];
  assign digits.status       = status;
  assign digits.run_end      = (idx == '0);

endmodule

// ===== rtl/rsc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rsc_pkg::ASCII_W-1:0]     digit_out,
  input logic [rsc_pkg::STATUS_W-1:0]    status,
  input logic                            run_end
);

  import rsc_pkg::*;

  // A stalled digit request keeps its digit and its run-end flag.
  `RSC_ASSERT_HS(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(digit_out) && $stable(run_end))

  // Input side stays closed while a run is on offer.
  `RSC_ASSERT(a_no_input_in_run, clk, rst, out_valid |-> !in_ready)

  // A digit taken before the end of its run keeps the input closed: more of the run follows.
  `RSC_ASSERT(a_run_continues, clk, rst, out_valid && out_ready && !run_end |=> !in_ready)

  `RSC_ASSERT(a_digit_ascii, clk, rst, out_valid |-> (digit_out >= 7'h30 && digit_out <= 7'h39) || (digit_out >= 7'h41 && digit_out <= 7'h4A))

  `RSC_ASSERT(a_status_code, clk, rst, out_valid |-> status == STATUS_OK || status == STATUS_BAD_DIGIT || status == STATUS_OVERFLOW)

endmodule

bind radix_string_converter rsc_checker u_rsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (chars.ready),
  .out_valid (digits.valid),
  .out_ready (digits.ready),
  .digit_out (digits.digit_out),
  .status    (digits.status),
  .run_end   (digits.run_end)
);
